[rtl/jfps_pkg.sv]
// Package for the JTAG flash program snooper: transaction structs, codes,
// TAP transition table and helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jfps_pkg;

  localparam int unsigned MaxTmsBits = 8;

  typedef enum logic [3:0] {
    FN_SOFT_RESET = 4'd0,
    FN_BEGIN      = 4'd1,
    FN_CAPTURE    = 4'd2,
    FN_OBSERVE    = 4'd3,
    FN_SUPPRESS   = 4'd4,
    FN_PREPARE    = 4'd5,
    FN_PENDING    = 4'd6,
    FN_WORD_DONE  = 4'd7,
    FN_ERASE_CHK  = 4'd8,
    FN_LONG_BYTE  = 4'd9
  } func_e;

  typedef enum logic [2:0] {
    DR_PASS = 3'd0, DR_ENTER = 3'd1, DR_COMMIT = 3'd2,
    DR_INVALID = 3'd3, DR_TAIL = 3'd4, DR_CAPTURED = 3'd5
  } dr_action_e;

  typedef enum logic [1:0] {
    LA_PASS = 2'd0, LA_SUPPRESS = 2'd1, LA_ERASE = 2'd2
  } long_action_e;

  typedef enum logic [2:0] {
    CFG_PREPARE = 3'd0, CFG_ADDR_IDLE = 3'd1, CFG_WORD_IDLE = 3'd2,
    CFG_LONG_MIN = 3'd3, CFG_IDLE_MAX = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {ST_IDLE, ST_TMS, ST_DONE} state_e;

  localparam logic [7:0] OpTmsWrite  = 8'h4B;
  localparam logic [7:0] IrProgram   = 8'h71;
  localparam logic [7:0] IrErase     = 8'h75;
  localparam logic [7:0] IrPrepare   = 8'h09;
  localparam logic [7:0] IrEndA      = 8'h15;
  localparam logic [7:0] IrEndB      = 8'h17;
  localparam logic [7:0] IrEndC      = 8'h05;
  localparam logic [7:0] OpBitsLsb   = 8'h1B;
  localparam logic [7:0] OpBytesLsb  = 8'h19;
  localparam logic [7:0] OpBytesMsb  = 8'h11;
  localparam logic [7:0] OpBitsMsb   = 8'h13;
  localparam logic [7:0] OpFlush     = 8'h87;

  localparam logic [3:0] TsReset   = 4'd0;
  localparam logic [3:0] TsIdle    = 4'd1;
  localparam logic [3:0] TsShiftDr = 4'd4;
  localparam logic [3:0] TsExit1Dr = 4'd5;
  localparam logic [3:0] TsShiftIr = 4'd11;

  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  opcode;
    logic [7:0]  data;
    logic [3:0]  bit_count;
    logic [15:0] remaining;
    logic [7:0]  arg_low;
    logic [7:0]  arg_high;
    logic [16:0] clk_bytes;
  } in_t;

  typedef struct packed {
    logic        flag;
    logic [2:0]  dr_action;
    logic [1:0]  long_action;
    logic [11:0] clock_count;
    logic [31:0] prog_word;
    logic [7:0]  word_tail;
    logic [3:0]  tap_position;
  } out_t;

  function automatic logic [3:0] tap_next(input logic [3:0] s, input logic tms);
    logic [3:0] r;
    case (s)
      4'd0:  r = tms ? 4'd0  : 4'd1;
      4'd1:  r = tms ? 4'd2  : 4'd1;
      4'd2:  r = tms ? 4'd9  : 4'd3;
      4'd3:  r = tms ? 4'd5  : 4'd4;
      4'd4:  r = tms ? 4'd5  : 4'd4;
      4'd5:  r = tms ? 4'd8  : 4'd6;
      4'd6:  r = tms ? 4'd7  : 4'd6;
      4'd7:  r = tms ? 4'd8  : 4'd4;
      4'd8:  r = tms ? 4'd2  : 4'd1;
      4'd9:  r = tms ? 4'd0  : 4'd10;
      4'd10: r = tms ? 4'd12 : 4'd11;
      4'd11: r = tms ? 4'd12 : 4'd11;
      4'd12: r = tms ? 4'd15 : 4'd13;
      4'd13: r = tms ? 4'd14 : 4'd13;
      4'd14: r = tms ? 4'd15 : 4'd11;
      default: r = tms ? 4'd2 : 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] flip_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/jtag_flash_program_snooper.sv]
// JTAG flash program snooper top level: TAP tracker, IR/DR capture, idle
// answers. Depends on jfps_pkg.
// Accept in ST_IDLE, result registered in ST_DONE; observe with a TMS opcode
// first steps the TAP once per TMS bit (up to 8, one shared TAP step unit).
// One transaction at a time; next accept in the cycle after the result is taken.
// Async active-low reset clears all control state and loads register
// defaults; captured word bytes are not reset.
`timescale 1ns / 1ps
`default_nettype none
module jtag_flash_program_snooper
  import jfps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);

  logic [11:0] prep_clk_q;
  logic [7:0]  addr_idle_q, word_idle_q;
  logic [16:0] long_min_q;
  logic [15:0] idle_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_clk_q  <= 12'd1200;
      addr_idle_q <= 8'd32;
      word_idle_q <= 8'd24;
      long_min_q  <= 17'd8000;
      idle_max_q  <= 16'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PREPARE:   prep_clk_q  <= cfg_data_i[11:0];
        CFG_ADDR_IDLE: addr_idle_q <= cfg_data_i[7:0];
        CFG_WORD_IDLE: word_idle_q <= cfg_data_i[7:0];
        CFG_LONG_MIN:  long_min_q  <= cfg_data_i;
        CFG_IDLE_MAX:  idle_max_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  in_t    in_q, in_d;
  out_t   out_q, out_d;
  logic   out_valid_q, out_valid_d;
  logic [3:0] tap_q, tap_d;
  logic       ir_wait_q, ir_wait_d;
  logic [6:0] ir_low_q, ir_low_d;
  logic [7:0] dr_ins_q, dr_ins_d;
  logic [2:0] stage_q, stage_d;
  logic [7:0] enter_q, enter_d;
  logic [7:0] idle_ins_q, idle_ins_d;
  logic       prep_wait_q, prep_wait_d, seen_q, seen_d;
  logic       armed_q, armed_d, blocked_q, blocked_d;
  logic [7:0] wb_q [4];
  logic [7:0] tail_q;
  logic       wb_we, tail_we;
  logic [1:0] wb_idx;
  logic [7:0] wb_val;
  logic [7:0] sh_q, sh_d;
  logic [3:0] cnt_q, cnt_d;

  assign in_stall_o  = (state_q != ST_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [7:0] ins;
    logic [7:0] mask;
    logic [3:0] n;
    ins = 8'd0;
    mask = 8'd0;
    n = 4'd0;
    state_d = state_q;
    in_d = in_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    tap_d = tap_q; ir_wait_d = ir_wait_q; ir_low_d = ir_low_q;
    dr_ins_d = dr_ins_q; stage_d = stage_q; enter_d = enter_q;
    idle_ins_d = idle_ins_q; prep_wait_d = prep_wait_q; seen_d = seen_q;
    armed_d = armed_q; blocked_d = blocked_q;
    sh_d = sh_q; cnt_d = cnt_q;
    wb_we = 1'b0; tail_we = 1'b0; wb_idx = 2'd0; wb_val = 8'd0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          in_d = in_data_i;
          out_d = '0;
          state_d = ST_DONE;
          case (in_data_i.func)
            FN_SOFT_RESET: begin
              dr_ins_d = '0; stage_d = '0; enter_d = '0; idle_ins_d = '0;
              prep_wait_d = 1'b0; seen_d = 1'b0; ir_wait_d = 1'b0;
              armed_d = 1'b0; blocked_d = 1'b0; ir_low_d = '0; tap_d = TsReset;
            end
            FN_BEGIN: begin
              if (enter_q != 0 && stage_q == 0)
                out_d.flag = in_data_i.opcode == OpBytesMsb ||
                             in_data_i.opcode == OpBytesLsb || in_data_i.opcode == OpFlush;
              else
                out_d.flag = stage_q == 0 || in_data_i.opcode == OpFlush ||
                  (stage_q == 3 && (in_data_i.opcode == OpBitsMsb ||
                                    in_data_i.opcode == OpBitsLsb)) ||
                  (stage_q >= 4 && in_data_i.opcode == OpTmsWrite);
            end
            FN_CAPTURE: begin
              if (dr_ins_q != 0 && tap_q == TsIdle && in_data_i.opcode == OpTmsWrite &&
                  in_data_i.bit_count == 4'd3 && in_data_i.data[2:0] == 3'd1) begin
                enter_d = in_data_i.data;
                out_d.dr_action = DR_ENTER;
              end else if (stage_q == 3'd5) begin
                if (tap_q == TsExit1Dr && in_data_i.opcode == OpTmsWrite &&
                    ((in_data_i.bit_count == 4'd2 && in_data_i.data[1:0] == 2'd1) ||
                     (in_data_i.bit_count == 4'd7 && in_data_i.data[6:0] == 7'd1))) begin
                  out_d.dr_action = DR_COMMIT;
                  out_d.prog_word = {wb_q[0], wb_q[1], wb_q[2], wb_q[3]};
                  out_d.word_tail = tail_q;
                end else out_d.dr_action = DR_INVALID;
              end else if (dr_ins_q == 0 || tap_q != TsShiftDr) begin
                out_d.dr_action = DR_PASS;
              end else if (stage_q == 3'd4) begin
                if (in_data_i.opcode != OpTmsWrite || in_data_i.bit_count != 4'd1 ||
                    !in_data_i.data[0])
                  out_d.dr_action = DR_INVALID;
                else begin
                  tail_we = 1'b1; stage_d = 3'd5; out_d.dr_action = DR_TAIL;
                end
              end else if ((in_data_i.opcode == OpBytesMsb ||
                            in_data_i.opcode == OpBytesLsb) &&
                           in_data_i.arg_low == 8'd2 && in_data_i.arg_high == 8'd0) begin
                if (in_data_i.remaining >= 16'd1 && in_data_i.remaining <= 16'd3 &&
                    {13'd0, stage_q} == 16'd3 - in_data_i.remaining) begin
                  wb_we = 1'b1; wb_idx = stage_q[1:0];
                  wb_val = in_data_i.opcode[3] ? flip_byte(in_data_i.data)
                                               : in_data_i.data;
                  stage_d = stage_q + 3'd1;
                  out_d.dr_action = DR_CAPTURED;
                end else out_d.dr_action = DR_INVALID;
              end else if ((in_data_i.opcode == OpBitsMsb ||
                            in_data_i.opcode == OpBitsLsb) &&
                           in_data_i.bit_count == 4'd7 && stage_q == 3'd3) begin
                wb_we = 1'b1; wb_idx = 2'd3;
                wb_val = in_data_i.opcode[3] ? flip_byte(in_data_i.data)
                                             : in_data_i.data;
                stage_d = 3'd4;
                out_d.dr_action = DR_CAPTURED;
              end else begin
                out_d.dr_action = (stage_q == 0 && enter_q == 0) ? DR_PASS : DR_INVALID;
              end
            end
            FN_OBSERVE: begin
              idle_ins_d = '0;
              ir_wait_d = ir_wait_q;
              ir_low_d = ir_low_q;
              if (in_data_i.opcode == OpBitsLsb && in_data_i.bit_count == 4'd7 &&
                  tap_q == TsShiftIr) begin
                ir_low_d = in_data_i.data[6:0];
                ir_wait_d = 1'b1;
              end
              if (in_data_i.opcode[6] && ir_wait_d) begin
                if (in_data_i.bit_count == 4'd1 && tap_q == TsShiftIr) begin
                  ins = {in_data_i.data[7], ir_low_d};
                  dr_ins_d = (ins == IrProgram || ins == IrErase) ? ins : 8'd0;
                  stage_d = '0; enter_d = '0; seen_d = 1'b0;
                  if (ins == IrPrepare) prep_wait_d = 1'b1;
                  else if (ins == IrErase || ins == IrEndA || ins == IrEndB ||
                           ins == IrEndC) prep_wait_d = 1'b0;
                end
                ir_wait_d = 1'b0;
              end
              if (in_data_i.opcode[6]) begin
                sh_d = in_data_i.data;
                cnt_d = (in_data_i.bit_count > 4'(MaxTmsBits)) ? 4'(MaxTmsBits)
                                                                : in_data_i.bit_count;
                state_d = ST_TMS;
              end
            end
            FN_SUPPRESS: begin
              n = in_data_i.bit_count;
              for (int i = 0; i < 8; i++) mask[i] = 4'(i) < n;
              if (tap_q == TsIdle && idle_ins_q != 0) begin
                if (in_data_i.opcode == OpTmsWrite && n <= 4'd7 &&
                    (in_data_i.data & mask) == 8'd0)
                  out_d.flag = 1'b1;
                else if (in_data_i.opcode == OpBytesLsb && in_data_i.data == 8'd0 &&
                         (idle_ins_q == IrErase || in_data_i.remaining <= idle_max_q)) begin
                  armed_d = 1'b0; blocked_d = 1'b1; out_d.flag = 1'b1;
                end
              end
            end
            FN_PREPARE: begin
              if (prep_wait_q && tap_q == TsIdle && in_data_i.opcode == OpTmsWrite &&
                  in_data_i.bit_count == 4'd4 && in_data_i.data[3:0] == 4'd3)
                out_d.clock_count = prep_clk_q;
            end
            FN_PENDING: begin
              if (dr_ins_q != IrErase)
                out_d.clock_count = {4'd0, seen_q ? word_idle_q : addr_idle_q};
            end
            FN_WORD_DONE: begin
              stage_d = '0; enter_d = '0; idle_ins_d = dr_ins_q;
              if (dr_ins_q == IrProgram) seen_d = 1'b1;
              if (dr_ins_q == IrErase) dr_ins_d = '0;
            end
            FN_ERASE_CHK: begin
              out_d.flag = !in_data_i.opcode[5] && in_data_i.clk_bytes >= long_min_q;
              if (out_d.flag) armed_d = 1'b1;
            end
            FN_LONG_BYTE: begin
              if (blocked_q) out_d.long_action = LA_SUPPRESS;
              else if (armed_q) begin
                armed_d = 1'b0;
                if (in_data_i.data == 8'd0) begin
                  blocked_d = 1'b1; out_d.long_action = LA_ERASE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_TMS: begin
        // one TAP transition per cycle
        if (cnt_q == 0) state_d = ST_DONE;
        else begin
          tap_d = tap_next(tap_q, sh_q[0]);
          if (tap_d == TsReset) begin
            dr_ins_d = '0; stage_d = '0; enter_d = '0; idle_ins_d = '0;
            prep_wait_d = 1'b0; seen_d = 1'b0; ir_wait_d = 1'b0;
          end
          sh_d = {1'b0, sh_q[7:1]};
          cnt_d = cnt_q - 4'd1;
        end
      end
      ST_DONE: begin
        out_d.tap_position = tap_q;
        out_valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; out_valid_q <= 1'b0;
      tap_q <= TsReset; ir_wait_q <= 1'b0; ir_low_q <= '0; dr_ins_q <= '0;
      stage_q <= '0; enter_q <= '0; idle_ins_q <= '0; prep_wait_q <= 1'b0;
      seen_q <= 1'b0; armed_q <= 1'b0; blocked_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q <= state_d; out_valid_q <= out_valid_d;
      tap_q <= tap_d; ir_wait_q <= ir_wait_d; ir_low_q <= ir_low_d;
      dr_ins_q <= dr_ins_d; stage_q <= stage_d; enter_q <= enter_d;
      idle_ins_q <= idle_ins_d; prep_wait_q <= prep_wait_d; seen_q <= seen_d;
      armed_q <= armed_d; blocked_q <= blocked_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    out_q <= out_d;
    sh_q <= sh_d;
    if (wb_we) wb_q[wb_idx] <= wb_val;
    if (tail_we) tail_q <= in_d.data;
  end

endmodule
`default_nettype wire
